// ===== rtl/core/sbl_pkg.sv =====
// Shared types and constants for the sorted block list.
// No dependencies; used by every file under rtl/core.
package sbl_pkg;

    localparam int CAPACITY = 64;
    localparam int BLK_W    = 24;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;
    localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ADD   = 2'd0;
    localparam t_cmd CMD_DEL   = 2'd1;
    localparam t_cmd CMD_CLEAR = 2'd2;
    localparam t_cmd CMD_READ  = 2'd3;

    typedef logic [2:0] t_status;
    localparam t_status STAT_OK       = 3'd0;
    localparam t_status STAT_DUP      = 3'd1;
    localparam t_status STAT_NOTFOUND = 3'd2;
    localparam t_status STAT_FULL     = 3'd3;
    localparam t_status STAT_RANGE    = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // Update strobe broadcast to every cell in the execute state of a command.
    typedef struct packed {
        logic             add_go;
        logic             del_go;
        logic [BLK_W-1:0] blk;
    } t_cell_ctl;

endpackage

// ===== rtl/core/sbl_cell.sv =====
// One cell of the sorted list: holds one entry and its compare flags.
// Depends on sbl_pkg; instantiated in a row by sorted_block_list.
module sbl_cell (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [sbl_pkg::BLK_W-1:0]   i_block,
    input  logic                        i_occ,
    input  logic                        i_sel,
    input  sbl_pkg::t_cell_ctl          i_ctl,
    input  logic [sbl_pkg::BLK_W-1:0]   i_left_value,
    input  logic                        i_left_ins,
    input  logic [sbl_pkg::BLK_W-1:0]   i_right_value,
    output logic [sbl_pkg::BLK_W-1:0]   o_value,
    output logic                        o_ins,
    output logic                        o_eq,
    output logic [sbl_pkg::BLK_W-1:0]   o_rd
);

    logic [sbl_pkg::BLK_W-1:0] r_value;
    logic [sbl_pkg::BLK_W-1:0] n_value;
    logic                      r_lt;
    logic                      r_eq;
    logic                      r_free;
    logic                      r_hit;

    // flags are sampled on the accept edge, while count is still the old one
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_lt   <= i_occ & (i_block < r_value);
            r_eq   <= i_occ & (i_block == r_value);
            r_free <= ~i_occ;
            r_hit  <= i_sel;
        end
        r_value <= n_value;
    end

    // insertion point and everything above it; monotone along the row
    assign o_ins   = r_free | r_lt;
    assign o_eq    = r_eq;
    assign o_value = r_value;
    assign o_rd    = r_hit ? r_value : '0;

    always_comb begin
        n_value = r_value;
        if (i_ctl.add_go && o_ins) begin
            n_value = i_left_ins ? i_left_value : i_ctl.blk;
        end else if (i_ctl.del_go && !r_free && (r_lt || r_eq)) begin
            n_value = i_right_value;
        end
    end

endmodule

// ===== rtl/core/sorted_block_list.sv =====
// Top level of the sorted block list: command control and the row of cells.
// Depends on sbl_pkg and sbl_cell.
//
//  channel | direction | handshake                | fields
//  --------+-----------+--------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_stall  | i_command, i_block_number, i_entry_index
//  out     | from block| o_out_valid / i_out_stall| o_status, o_entry_count, o_read_block
//
// For every command, on the accept edge all cells compare against the block
// number in parallel; then in the execute state, once the output side is free,
// the row shifts in one step and count and status settle into the output register.
// A new beat is taken only after the previous command has left the execute state;
// the execute state waits while a previous result is still stalled on the output.
// Reset (i_rst_n low, synchronous) empties the list and clears the output valid flag.
module sorted_block_list (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [sbl_pkg::BLK_W-1:0]     i_block_number,
    input  logic [sbl_pkg::IDX_W-1:0]     i_entry_index,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [2:0]                    o_status,
    output logic [sbl_pkg::OUT_CNT_W-1:0] o_entry_count,
    output logic [sbl_pkg::BLK_W-1:0]     o_read_block
);

    localparam int N = sbl_pkg::CAPACITY;

    sbl_pkg::t_state             r_state;
    sbl_pkg::t_state             n_state;
    logic [sbl_pkg::CNT_W-1:0]   r_count;
    logic [sbl_pkg::CNT_W-1:0]   n_count;
    sbl_pkg::t_cmd               r_cmd;
    logic [sbl_pkg::BLK_W-1:0]   r_blk;
    logic                        r_rd_ok;
    logic                        r_out_valid;
    sbl_pkg::t_status            r_status;
    sbl_pkg::t_status            n_status;
    logic [sbl_pkg::OUT_CNT_W-1:0] r_entry_count;
    logic [sbl_pkg::BLK_W-1:0]   r_read_block;
    logic [sbl_pkg::BLK_W-1:0]   n_read_block;

    logic                        in_acc;
    logic                        go;
    logic                        any_eq;
    logic                        full;
    logic [sbl_pkg::BLK_W-1:0]   rd_or;
    sbl_pkg::t_cell_ctl          cell_ctl;
    logic [sbl_pkg::CNT_W+sbl_pkg::OUT_CNT_W-1:0] cnt_ext;

    logic [N-1:0]                occ;
    logic [N-1:0]                sel;
    logic [N-1:0]                ins;
    logic [N-1:0]                eq;
    logic [sbl_pkg::BLK_W-1:0]   value [N];
    logic [sbl_pkg::BLK_W-1:0]   rd    [N];

    assign in_acc = i_in_valid & ~o_in_stall;

    // ---- control FSM ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbl_pkg::S_IDLE: if (in_acc) n_state = sbl_pkg::S_EXEC;
            sbl_pkg::S_EXEC: if (go)     n_state = sbl_pkg::S_IDLE;
            default:                     n_state = sbl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != sbl_pkg::S_IDLE);
        go         = (r_state == sbl_pkg::S_EXEC) && (!r_out_valid || !i_out_stall);
    end

    // ---- result of the command in flight ----
    always_comb begin
        any_eq = |eq;
        rd_or  = '0;
        for (int k = 0; k < N; k++) begin
            rd_or = rd_or | rd[k];
        end
    end

    assign full = (r_count >= sbl_pkg::CNT_W'(N));

    always_comb begin
        n_status         = sbl_pkg::STAT_OK;
        n_count          = r_count;
        n_read_block     = '0;
        cell_ctl.add_go  = 1'b0;
        cell_ctl.del_go  = 1'b0;
        cell_ctl.blk     = r_blk;
        unique case (r_cmd)
            sbl_pkg::CMD_ADD: begin
                if (full) begin
                    n_status = sbl_pkg::STAT_FULL;
                end else if (any_eq) begin
                    n_status = sbl_pkg::STAT_DUP;
                end else begin
                    n_count         = r_count + sbl_pkg::CNT_W'(1);
                    cell_ctl.add_go = go;
                end
            end
            sbl_pkg::CMD_DEL: begin
                if (any_eq) begin
                    n_count         = r_count - sbl_pkg::CNT_W'(1);
                    cell_ctl.del_go = go;
                end else begin
                    n_status = sbl_pkg::STAT_NOTFOUND;
                end
            end
            sbl_pkg::CMD_CLEAR: begin
                n_count = '0;
            end
            sbl_pkg::CMD_READ: begin
                if (r_rd_ok) n_read_block = rd_or;
                else         n_status     = sbl_pkg::STAT_RANGE;
            end
            default: n_status = sbl_pkg::STAT_OK;
        endcase
    end

    assign cnt_ext = {{sbl_pkg::OUT_CNT_W{1'b0}}, n_count};

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbl_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_command;
            r_blk   <= i_block_number;
            r_rd_ok <= (sbl_pkg::CMP_W'(i_entry_index) < sbl_pkg::CMP_W'(r_count));
        end
        if (go) begin
            r_status      <= n_status;
            r_entry_count <= cnt_ext[sbl_pkg::OUT_CNT_W-1:0];
            r_read_block  <= n_read_block;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;
    assign o_read_block  = r_read_block;

    // ---- row of cells ----
    for (genvar i = 0; i < N; i++) begin : g_cell
        assign occ[i] = (sbl_pkg::CNT_W'(i) < r_count);
        assign sel[i] = (sbl_pkg::CMP_W'(i) == sbl_pkg::CMP_W'(i_entry_index));

        sbl_cell u_cell (
            .i_clk         (i_clk),
            .i_load        (in_acc),
            .i_block       (i_block_number),
            .i_occ         (occ[i]),
            .i_sel         (sel[i]),
            .i_ctl         (cell_ctl),
            .i_left_value  ((i == 0) ? '0 : value[(i == 0) ? 0 : i-1]),
            .i_left_ins    ((i == 0) ? 1'b0 : ins[(i == 0) ? 0 : i-1]),
            .i_right_value ((i == N-1) ? '0 : value[(i == N-1) ? N-1 : i+1]),
            .o_value       (value[i]),
            .o_ins         (ins[i]),
            .o_eq          (eq[i]),
            .o_rd          (rd[i])
        );
    end

endmodule

// ===== rtl/core/sbl_checker.sv =====
// Port-level checks for sorted_block_list, attached by bind.
// Depends on sbl_pkg and the top level's ports.
module sbl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [2:0]                    o_status,
    input logic [sbl_pkg::OUT_CNT_W-1:0] o_entry_count,
    input logic [sbl_pkg::BLK_W-1:0]     o_read_block
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat pending after reset");

    a_stalled_beat_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status) && $stable(o_entry_count)
            && $stable(o_read_block))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken while a command is in flight");

    a_read_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != sbl_pkg::STAT_OK) |-> (o_read_block == '0))
        else $error("nonzero read data with error status");

endmodule

bind sorted_block_list sbl_checker u_sbl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_entry_count (o_entry_count),
    .o_read_block  (o_read_block)
);
